// ===== sv/cled_pkg.sv =====
`timescale 1ns / 1ps

package cled_pkg;

   // Chain length and the frame that follows from it
   localparam int LED_COUNT   = 1;
   localparam int FRAME_BYTES = 8 + 4 * LED_COUNT;
   localparam int CNT_W       = $clog2(FRAME_BYTES);

   localparam logic [7:0] FLAG_BASE = 8'hC0;
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   // Request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Byte position inside one LED group
   localparam logic [1:0] PH_FLAG  = 2'd0;
   localparam logic [1:0] PH_BLUE  = 2'd1;
   localparam logic [1:0] PH_GREEN = 2'd2;
   localparam logic [1:0] PH_RED   = 2'd3;

   typedef struct packed {
      logic       op;
      logic [3:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
      logic [7:0] read_red;
      logic [7:0] read_green;
      logic [7:0] read_blue;
      logic       index_bad;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic emit_read;
      logic emit_frame;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic frame_done;
   } stat_type;

   // Flag byte: 0xC0 with the inverted top two bits of blue, green, red
   function automatic logic [7:0] flag_byte(input color_type c);
      logic [7:0] f;
      f = FLAG_BASE;
      f[5:4] = ~c.blue[7:6];
      f[3:2] = ~c.green[7:6];
      f[1:0] = ~c.red[7:6];
      return f;
   endfunction

endpackage

// ===== sv/chainable_rgb_led_frame_gen.sv =====
`timescale 1ns / 1ps

// Chainable RGB LED frame generator.
// Request channel: drive req_item and raise start; the item is taken at a
// rising edge where start is high and busy is low. op selects write or read.
// Result channel: each result sits on rsp_item for one cycle with rsp_valid
// high. The receiver cannot stall; it must take every result as it comes.
// A write stores the color (unless led_index is out of range) and then
// emits the whole frame: four zero bytes, per LED a flag byte then blue,
// green and red, then four zero bytes. That is 8 + 4*LED_COUNT results, one
// per cycle; the state register and then the result register lie between
// accept and the first one. The frame byte counter sets the pace, and busy
// stays high through the whole sweep, so no new item is taken meanwhile.
// A read returns a single registered result and holds busy for one
// cycle. index_bad marks every result of an item whose index is past the
// chain. Reset clears all stored colors to black and returns to idle.
module chainable_rgb_led_frame_gen (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cled_pkg::req_type req_item,
   output logic              rsp_valid,
   output cled_pkg::rsp_type rsp_item
);
   import cled_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence the item: idle, then a read cycle or a frame sweep
   cled_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_item.op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Hold the colors, build each byte, register the result
   cled_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== sv/cled_ctrl.sv =====
`timescale 1ns / 1ps

module cled_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_op,
   input  cled_pkg::stat_type stat,
   output cled_pkg::cmd_type  cmd,
   output logic             busy
);
   import cled_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FRAME
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_op == OP_READ) ? ST_READ : ST_FRAME;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_FRAME: begin
            if (stat.frame_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign cmd.load       = accept;
   assign cmd.emit_read  = (state_ff == ST_READ);
   assign cmd.emit_frame = (state_ff == ST_FRAME);

   a_frame_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FRAME && !stat.frame_done |=> state_ff == ST_FRAME)
      else $error("frame sweep left early");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_IDLE)
      else $error("read did not finish in one cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

endmodule

// ===== sv/cled_datapath.sv =====
`timescale 1ns / 1ps

module cled_datapath (
   input  logic               clock,
   input  logic               reset,
   input  cled_pkg::req_type  req_item,
   input  cled_pkg::cmd_type  cmd,
   output cled_pkg::stat_type stat,
   output logic               rsp_valid,
   output cled_pkg::rsp_type  rsp_item
);
   import cled_pkg::*;

   color_type            store_ff [LED_COUNT];
   logic [3:0]           idx_ff;
   logic                 bad_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 req_bad;
   logic [CNT_W-1:0]     grp;
   logic [1:0]           phase;
   logic [3:0]           rd_addr;
   color_type            rd_color;
   logic                 in_led;
   logic [7:0]           frame_byte;
   rsp_type              rsp_in;

   assign req_bad = ({1'b0, req_item.led_index} >= 5'(LED_COUNT));
   assign grp     = cnt_ff >> 2;
   assign phase   = cnt_ff[1:0];
   assign in_led  = (grp != '0) && (grp <= CNT_W'(LED_COUNT));

   // Single read port: read index on reads, current LED group on frames
   assign rd_addr = cmd.emit_read ? idx_ff : 4'(grp - CNT_W'(1));

   always_comb begin
      rd_color = '0;
      for (int i = 0; i < LED_COUNT; i++) begin
         if (rd_addr == 4'(i)) begin
            rd_color = store_ff[i];
         end
      end
   end

   always_comb begin
      frame_byte = ZERO_BYTE;
      if (in_led) begin
         case (phase)
            PH_FLAG:  frame_byte = flag_byte(rd_color);
            PH_BLUE:  frame_byte = rd_color.blue;
            PH_GREEN: frame_byte = rd_color.green;
            PH_RED:   frame_byte = rd_color.red;
            default:  frame_byte = ZERO_BYTE;
         endcase
      end
   end

   assign stat.frame_done = (cnt_ff == CNT_W'(FRAME_BYTES - 1));

   always_comb begin
      rsp_in = '0;
      rsp_in.index_bad = bad_ff;
      if (cmd.emit_read) begin
         rsp_in.frame_last = 1'b1;
         if (!bad_ff) begin
            rsp_in.read_red   = rd_color.red;
            rsp_in.read_green = rd_color.green;
            rsp_in.read_blue  = rd_color.blue;
         end
      end else begin
         rsp_in.frame_byte = frame_byte;
         rsp_in.frame_last = stat.frame_done;
      end
   end

   // Store: cleared at reset, written on an accepted write with a good index
   always_ff @(posedge clock) begin
      for (int i = 0; i < LED_COUNT; i++) begin
         if (reset) begin
            store_ff[i] <= '0;
         end else if (cmd.load && req_item.op == OP_WRITE && !req_bad
                      && req_item.led_index == 4'(i)) begin
            store_ff[i] <= '{red: req_item.red, green: req_item.green,
                             blue: req_item.blue};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.emit_frame) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         rsp_valid_ff <= cmd.emit_read || cmd.emit_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= req_item.led_index;
         bad_ff <= req_bad;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_frame_ends_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_frame && stat.frame_done |=> rsp_valid_ff && rsp_ff.frame_last)
      else $error("frame end not marked last");

   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_read |=> rsp_valid_ff && rsp_ff.frame_last
                        && rsp_ff.frame_byte == ZERO_BYTE)
      else $error("read result malformed");

   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_read && bad_ff |=> rsp_ff.read_red == 8'd0
         && rsp_ff.read_green == 8'd0 && rsp_ff.read_blue == 8'd0)
      else $error("out of range read returned a color");

endmodule
